// ----- design/spaq_pkg.sv -----
// shared types and constants for the sorted array priority queue
`timescale 1ns / 1ps

package spaq_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ----- design/spaq_cell.sv -----
// one slot of the sorted row, shifts toward its neighbors on insert and remove
`timescale 1ns / 1ps

module spaq_cell (
  input  logic                     clk_i,
  input  spaq_pkg::cell_ctrl_t     ctrl_i,
  input  logic                     occupied_i,
  input  logic signed [spaq_pkg::DATA_W-1:0] value_i,
  input  logic                     left_gt_i,
  input  logic signed [spaq_pkg::DATA_W-1:0] left_entry_i,
  input  logic signed [spaq_pkg::DATA_W-1:0] right_entry_i,
  output logic                     gt_o,
  output logic signed [spaq_pkg::DATA_W-1:0] entry_o
);

  import spaq_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;

  // empty slots count as greater so the new value lands at the first one
  assign gt_o = !occupied_i || (entry_q > value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_o) begin
      entry_d = left_gt_i ? left_entry_i : value_i;
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- design/sorted_array_priority_queue.sv -----
// top level of the sorted array priority queue built from a row of cells
//
// Input channel: in_valid_i / in_stall_o carry one beat per command, op_i
// selects insert (value_i) or removal of the smallest entry. Output channel:
// out_valid_o / out_stall_i carry one result beat per command: status, the
// removed value, the smallest and largest entries and the entry count.
// The row of cells updates in the accept cycle; once the output register is
// free, the pending stage reads the head cell and the tail cell selected by
// the count into the output register. One command is in flight at a time,
// so the block takes no new command beat until the single pending stage
// ahead of the output has passed its result on into the output register.
// A command may be accepted while the previous result waits in the output
// register; if the receiver keeps stalling, the second result is held back
// and in_stall_o stays high until the output register frees up.
// Rejected commands (insert when full, removal when empty) leave the queue
// unchanged and report it in status.
// Reset empties the queue and drops any pending result.
`timescale 1ns / 1ps

module sorted_array_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic signed [spaq_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [spaq_pkg::DATA_W-1:0] removed_value_o,
  output logic signed [spaq_pkg::DATA_W-1:0] head_value_o,
  output logic signed [spaq_pkg::DATA_W-1:0] tail_value_o,
  output logic [spaq_pkg::CNT_W-1:0]         count_o
);

  import spaq_pkg::*;

  logic signed [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]         gt;
  logic [DEPTH-1:0]         occ;
  cell_ctrl_t               ctrl;

  logic                     in_acc, out_free, full, empty;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     pend_q;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic                     out_valid_q;
  logic [1:0]               out_status_q;
  logic signed [DATA_W-1:0] out_removed_q, out_head_q, out_tail_q;
  logic [CNT_W-1:0]         out_count_q;
  logic [IDX_W-1:0]         tail_idx;

  assign in_stall_o = pend_q;
  assign in_acc     = in_valid_i && !pend_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.ins  = in_acc && (op_e'(op_i) == OP_INSERT) && !full;
    ctrl.rem  = in_acc && (op_e'(op_i) == OP_REMOVE) && !empty;
    count_d   = count_q;
    status_d  = ST_DONE;
    removed_d = '0;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.rem) begin
      count_d   = count_q - 1'b1;
      removed_d = entry[0];
    end
    if (op_e'(op_i) == OP_INSERT && full) begin
      status_d = ST_FULL;
    end else if (op_e'(op_i) == OP_REMOVE && empty) begin
      status_d = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (count_q > CNT_W'(i));
    spaq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occ[i]),
      .value_i      (value_i),
      .left_gt_i    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .left_entry_i (entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i(entry[(i == DEPTH - 1) ? i : i + 1]),
      .gt_o         (gt[i]),
      .entry_o      (entry[i])
    );
  end

  assign tail_idx = IDX_W'(count_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (pend_q && out_free) begin
        pend_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
    if (pend_q && out_free) begin
      out_status_q  <= status_q;
      out_removed_q <= removed_q;
      out_head_q    <= empty ? '0 : entry[0];
      out_tail_q    <= empty ? '0 : entry[tail_idx];
      out_count_q   <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign head_value_o    = out_head_q;
  assign tail_value_o    = out_tail_q;
  assign count_o         = out_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_accept_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_q)
    else $error("accepted beat lost before the result stage");

  a_sorted_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o != '0 |-> head_value_o <= tail_value_o)
    else $error("head above tail");

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the sorted array priority queue
`timescale 1ns / 1ps

module testbench;
  import spaq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  removed;
    logic signed [DATA_W-1:0]  head;
    logic signed [DATA_W-1:0]  tail;
    logic [CNT_W-1:0]          count;
  } pq_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        op_i = 1'b0;
  logic signed [DATA_W-1:0]    value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [1:0]                  status_o;
  logic signed [DATA_W-1:0]    removed_value_o;
  logic signed [DATA_W-1:0]    head_value_o;
  logic signed [DATA_W-1:0]    tail_value_o;
  logic [CNT_W-1:0]            count_o;

  logic signed [DATA_W-1:0]    sorted_q[$];
  pq_result_t                  pending_results[$];
  int                          fail_count = 0;
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          hold_left = 0;

  sorted_array_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .head_value_o    (head_value_o),
    .tail_value_o    (tail_value_o),
    .count_o         (count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // queue predictor: insert after equal entries, remove from the front
  task automatic predict_cmd(input op_e op, input logic signed [DATA_W-1:0] value);
    pq_result_t r;
    int pos;
    r.status  = ST_DONE;
    r.removed = '0;
    if (op == OP_INSERT) begin
      if (sorted_q.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = sorted_q.size();
        while (pos > 0 && sorted_q[pos-1] > value) pos--;
        sorted_q.insert(pos, value);
      end
    end else if (sorted_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = sorted_q.pop_front();
    end
    r.head  = (sorted_q.size() != 0) ? sorted_q[0] : '0;
    r.tail  = (sorted_q.size() != 0) ? sorted_q[sorted_q.size()-1] : '0;
    r.count = CNT_W'(sorted_q.size());
    pending_results.push_back(r);
  endtask

  task automatic send_cmd(input op_e op, input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    predict_cmd(op, value);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      4, 5, 6: pick_value = $urandom_range(8) - 4;
      7:       pick_value = VAL_MIN + $urandom_range(3);
      8:       pick_value = VAL_MAX - $urandom_range(3);
      9:       pick_value = (sorted_q.size() != 0) ?
                            sorted_q[$urandom_range(sorted_q.size()-1)] : $urandom;
      default: pick_value = $urandom;
    endcase
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker
  initial begin
    pq_result_t r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d removed %0d count %0d",
                     status_o, removed_value_o, count_o);
        end else begin
          r = pending_results.pop_front();
          if (status_o !== r.status || removed_value_o !== r.removed ||
              head_value_o !== r.head || tail_value_o !== r.tail ||
              count_o !== r.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp st %0d rm %0d hd %0d tl %0d cnt %0d, ",
                        "got st %0d rm %0d hd %0d tl %0d cnt %0d"},
                       r.status, r.removed, r.head, r.tail, r.count, status_o,
                       removed_value_o, head_value_o, tail_value_o, count_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic test_empty_removal();
    send_cmd(OP_REMOVE, 32'sh1234_5678);
  endtask

  task automatic test_fill_with_extremes();
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, VAL_MIN);
    send_cmd(OP_INSERT, 32'sd0);
    send_cmd(OP_INSERT, -32'sd1);
    send_cmd(OP_INSERT, 32'sd1);
    send_cmd(OP_INSERT, -32'sd1);
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, VAL_MIN);
    repeat (DEPTH - 8) send_cmd(OP_INSERT, pick_value());
  endtask

  task automatic test_full_insert();
    send_cmd(OP_INSERT, 32'sh5A5A_5A5A);
  endtask

  task automatic test_removal_order();
    repeat (3) send_cmd(OP_REMOVE, -32'sd1);
  endtask

  // bursts lean toward inserts or removals so the queue swings full and empty
  task automatic test_mixed_traffic(input int n_items, input int s_pct, input int r_pct);
    int left;
    int burst;
    int ins_pct;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(48, 16);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      while (burst > 0 && left > 0) begin
        send_cmd(op_e'(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE),
                 pick_value());
        burst--;
        left--;
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    repeat (60)
      send_cmd(op_e'(($urandom_range(99) < 70) ? OP_INSERT : OP_REMOVE), pick_value());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36;
    recv_idle_pct = 71;
    test_empty_removal();
    test_fill_with_extremes();
    test_full_insert();
    test_removal_order();
    test_mixed_traffic(620, 36, 71);
    test_mixed_traffic(620, 71, 36);
    test_mixed_traffic(620, 0, 0);
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
